FILE: rtl/tts_pkg.sv
package tts_pkg;

    localparam int DIFF_W = 33;
    localparam int PROD_W = 66;
    localparam int WIDE_W = 67;
    localparam int QUO_W  = 32;

    localparam logic [2:0] PAIR_DET  = 3'd0;
    localparam logic [2:0] PAIR_LAST = 3'd6;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
    } tts_vertex_t;

    typedef struct packed {
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
        logic signed [31:0] bitangent_x;
        logic signed [31:0] bitangent_y;
        logic signed [31:0] bitangent_z;
        logic               degenerate;
    } tts_result_t;

    typedef struct packed {
        logic       hold0;
        logic       hold1;
        logic       load3;
        logic [2:0] pair;
        logic       sel_b;
        logic       mul_en;
        logic       acc_load;
        logic       sub_en;
        logic       det_store;
        logic       div_init;
        logic       div_step;
        logic       res_store;
        logic       out_load;
        logic       out_degen;
    } tts_cmd_t;

    typedef struct packed {
        logic det_zero;
    } tts_status_t;

endpackage

FILE: rtl/tts_datapath.sv
module tts_datapath
    import tts_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  logic        clk,
    input  tts_vertex_t vertex,
    input  tts_cmd_t    cmd,
    output tts_status_t status,
    output tts_result_t result
);

    localparam int NW = WIDE_W + FRAC_BITS;
    localparam int CW = (NW > WIDE_W + QUO_W) ? NW : WIDE_W + QUO_W;

    logic signed [31:0] p0_reg [3];
    logic signed [31:0] uv0_reg [2];
    logic signed [31:0] p1_reg [3];
    logic signed [31:0] uv1_reg [2];

    logic signed [DIFF_W-1:0] dp1_reg [3];
    logic signed [DIFF_W-1:0] dp2_reg [3];
    logic signed [DIFF_W-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;

    logic signed [PROD_W-1:0] prod_reg, acc_reg;
    logic signed [WIDE_W-1:0] num_reg;
    logic        [WIDE_W-1:0] det_mag_reg;
    logic                     det_neg_reg, det_zero_reg;

    logic [WIDE_W-1:0] rem_reg;
    logic [QUO_W-1:0]  nlow_reg, q_reg;
    logic              ovf_reg, neg_reg;

    logic signed [31:0] res_reg [6];
    tts_result_t        result_reg;

    logic signed [DIFF_W-1:0] opa, opb;
    logic signed [WIDE_W-1:0] diff;
    logic        [WIDE_W-1:0] diff_mag, num_mag;
    logic        [NW-1:0]     nfull;
    logic        [CW-1:0]     nwide, dwide;
    logic        [WIDE_W:0]   trial, trial_sub;
    logic                     trial_ge;
    logic signed [31:0]       sat_val;
    logic        [2:0]        res_idx;

    function automatic logic signed [DIFF_W-1:0] sub33(logic signed [31:0] a,
                                                       logic signed [31:0] b);
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    always_comb
    begin
        opa = du1_reg;
        opb = dv2_reg;
        unique case (cmd.pair)
            3'd0:
            begin
                opa = cmd.sel_b ? du2_reg : du1_reg;
                opb = cmd.sel_b ? dv1_reg : dv2_reg;
            end
            3'd1:
            begin
                opa = cmd.sel_b ? dv1_reg : dv2_reg;
                opb = cmd.sel_b ? dp2_reg[0] : dp1_reg[0];
            end
            3'd2:
            begin
                opa = cmd.sel_b ? dv1_reg : dv2_reg;
                opb = cmd.sel_b ? dp2_reg[1] : dp1_reg[1];
            end
            3'd3:
            begin
                opa = cmd.sel_b ? dv1_reg : dv2_reg;
                opb = cmd.sel_b ? dp2_reg[2] : dp1_reg[2];
            end
            3'd4:
            begin
                opa = cmd.sel_b ? du2_reg : du1_reg;
                opb = cmd.sel_b ? dp1_reg[0] : dp2_reg[0];
            end
            3'd5:
            begin
                opa = cmd.sel_b ? du2_reg : du1_reg;
                opb = cmd.sel_b ? dp1_reg[1] : dp2_reg[1];
            end
            3'd6:
            begin
                opa = cmd.sel_b ? du2_reg : du1_reg;
                opb = cmd.sel_b ? dp1_reg[2] : dp2_reg[2];
            end
            default:
            begin
                opa = du1_reg;
                opb = dv2_reg;
            end
        endcase
    end

    always_comb
    begin
        diff      = WIDE_W'(acc_reg) - WIDE_W'(prod_reg);
        diff_mag  = diff[WIDE_W-1] ? WIDE_W'(-diff) : WIDE_W'(diff);
        num_mag   = num_reg[WIDE_W-1] ? WIDE_W'(-num_reg) : WIDE_W'(num_reg);
        nfull     = {num_mag, {FRAC_BITS{1'b0}}};
        nwide     = CW'(nfull);
        dwide     = CW'({det_mag_reg, {QUO_W{1'b0}}});
        trial     = {rem_reg, nlow_reg[QUO_W-1]};
        trial_ge  = trial >= {1'b0, det_mag_reg};
        trial_sub = trial - {1'b0, det_mag_reg};
        if (neg_reg)
        begin
            sat_val = (ovf_reg || q_reg > 32'h8000_0000) ? SAT_MIN : 32'(-q_reg);
        end
        else
        begin
            sat_val = (ovf_reg || q_reg[QUO_W-1]) ? SAT_MAX : 32'(q_reg);
        end
        res_idx = cmd.pair - 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hold0)
        begin
            p0_reg[0]  <= vertex.pos_x;
            p0_reg[1]  <= vertex.pos_y;
            p0_reg[2]  <= vertex.pos_z;
            uv0_reg[0] <= vertex.tex_u;
            uv0_reg[1] <= vertex.tex_v;
        end
        if (cmd.hold1)
        begin
            p1_reg[0]  <= vertex.pos_x;
            p1_reg[1]  <= vertex.pos_y;
            p1_reg[2]  <= vertex.pos_z;
            uv1_reg[0] <= vertex.tex_u;
            uv1_reg[1] <= vertex.tex_v;
        end
        if (cmd.load3)
        begin
            dp1_reg[0] <= sub33(p1_reg[0], p0_reg[0]);
            dp1_reg[1] <= sub33(p1_reg[1], p0_reg[1]);
            dp1_reg[2] <= sub33(p1_reg[2], p0_reg[2]);
            dp2_reg[0] <= sub33(vertex.pos_x, p0_reg[0]);
            dp2_reg[1] <= sub33(vertex.pos_y, p0_reg[1]);
            dp2_reg[2] <= sub33(vertex.pos_z, p0_reg[2]);
            du1_reg    <= sub33(uv1_reg[0], uv0_reg[0]);
            dv1_reg    <= sub33(uv1_reg[1], uv0_reg[1]);
            du2_reg    <= sub33(vertex.tex_u, uv0_reg[0]);
            dv2_reg    <= sub33(vertex.tex_v, uv0_reg[1]);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= opa * opb;
        end
        if (cmd.acc_load)
        begin
            acc_reg <= prod_reg;
        end
        if (cmd.sub_en)
        begin
            num_reg <= diff;
        end
        if (cmd.det_store)
        begin
            det_mag_reg  <= diff_mag;
            det_neg_reg  <= diff[WIDE_W-1];
            det_zero_reg <= (diff == '0);
        end
        if (cmd.div_init)
        begin
            ovf_reg  <= nwide >= dwide;
            neg_reg  <= num_reg[WIDE_W-1] ^ det_neg_reg;
            rem_reg  <= nwide[QUO_W+WIDE_W-1:QUO_W];
            nlow_reg <= nfull[QUO_W-1:0];
            q_reg    <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= trial_ge ? trial_sub[WIDE_W-1:0] : trial[WIDE_W-1:0];
            nlow_reg <= {nlow_reg[QUO_W-2:0], 1'b0};
            q_reg    <= {q_reg[QUO_W-2:0], trial_ge};
        end
        if (cmd.res_store)
        begin
            res_reg[res_idx] <= sat_val;
        end
        if (cmd.out_load)
        begin
            if (cmd.out_degen)
            begin
                result_reg <= '{default: '0, degenerate: 1'b1};
            end
            else
            begin
                result_reg.tangent_x   <= res_reg[0];
                result_reg.tangent_y   <= res_reg[1];
                result_reg.tangent_z   <= res_reg[2];
                result_reg.bitangent_x <= res_reg[3];
                result_reg.bitangent_y <= res_reg[4];
                result_reg.bitangent_z <= res_reg[5];
                result_reg.degenerate  <= 1'b0;
            end
        end
    end

    assign status.det_zero = det_zero_reg;
    assign result          = result_reg;

endmodule

FILE: rtl/tts_ctrl.sv
module tts_ctrl
    import tts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        vertex_valid,
    output logic        vertex_stall,
    output logic        result_valid,
    input  logic        result_stall,
    input  tts_status_t status,
    output tts_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MA    = 3'd1;
    localparam logic [2:0] S_MB    = 3'd2;
    localparam logic [2:0] S_SUB   = 3'd3;
    localparam logic [2:0] S_DINIT = 3'd4;
    localparam logic [2:0] S_DSTEP = 3'd5;
    localparam logic [2:0] S_DFIN  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] count_reg, count_next;
    logic [2:0] pair_reg, pair_next;
    logic [4:0] step_reg, step_next;
    logic       degen_reg, degen_next;
    logic       valid_reg, valid_next;
    logic       accept;

    assign vertex_stall = (state_reg != S_IDLE);
    assign accept       = vertex_valid && !vertex_stall;
    assign result_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pair_next  = pair_reg;
        step_next  = step_reg;
        degen_next = degen_reg;
        cmd        = '0;
        cmd.pair   = pair_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (count_reg)
                        2'd0:
                        begin
                            cmd.hold0  = 1'b1;
                            count_next = 2'd1;
                        end
                        2'd1:
                        begin
                            cmd.hold1  = 1'b1;
                            count_next = 2'd2;
                        end
                        default:
                        begin
                            cmd.load3  = 1'b1;
                            count_next = 2'd0;
                            pair_next  = PAIR_DET;
                            degen_next = 1'b0;
                            state_next = S_MA;
                        end
                    endcase
                end
            end
            S_MA:
            begin
                cmd.mul_en = 1'b1;
                if (pair_reg == 3'd1 && status.det_zero)
                begin
                    degen_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MB;
                end
            end
            S_MB:
            begin
                cmd.mul_en   = 1'b1;
                cmd.sel_b    = 1'b1;
                cmd.acc_load = 1'b1;
                state_next   = S_SUB;
            end
            S_SUB:
            begin
                cmd.sub_en    = 1'b1;
                cmd.det_store = (pair_reg == PAIR_DET);
                if (pair_reg == PAIR_DET)
                begin
                    pair_next  = 3'd1;
                    state_next = S_MA;
                end
                else
                begin
                    state_next = S_DINIT;
                end
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 5'd1;
                if (step_reg == 5'd31)
                begin
                    state_next = S_DFIN;
                end
            end
            S_DFIN:
            begin
                cmd.res_store = 1'b1;
                if (pair_reg == PAIR_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pair_next  = pair_reg + 3'd1;
                    state_next = S_MA;
                end
            end
            S_DONE:
            begin
                if (!valid_reg || !result_stall)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_degen = degen_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pair_reg  <= '0;
            step_reg  <= '0;
            degen_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pair_reg  <= pair_next;
            step_reg  <= step_next;
            degen_reg <= degen_next;
            valid_reg <= valid_next;
        end
    end

endmodule

FILE: rtl/triangle_tangent_solver.sv
// The first two vertices of a triangle are taken and held while the solver is idle.
// The third vertex starts the work: 14 products on one shared
// 33x33 multiplier and six 32-step quotients on one radix-2 divider.
// A triangle with a zero uv determinant skips the quotients and gives a degenerate result.
// No vertex is taken while a triangle is being solved.
// Reset clears the vertex count and the result valid; held data is not cleared.
module triangle_tangent_solver
    import tts_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        vertex_valid,
    output logic        vertex_stall,
    input  tts_vertex_t vertex,
    output logic        result_valid,
    input  logic        result_stall,
    output tts_result_t result
);

    tts_cmd_t    cmd;
    tts_status_t status;

    tts_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    tts_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk    (clk),
        .vertex (vertex),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

FILE: rtl/tts_checker.sv
module tts_checker
    import tts_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        vertex_valid,
    input logic        vertex_stall,
    input tts_vertex_t vertex,
    input logic        result_valid,
    input logic        result_stall,
    input tts_result_t result
);

    a_vertex_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && vertex_stall |=> vertex_valid && $stable(vertex))
        else $error("stalled vertex request dropped or changed");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result request dropped or changed");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.degenerate |->
            result.tangent_x == 0 && result.tangent_y == 0 && result.tangent_z == 0 &&
            result.bitangent_x == 0 && result.bitangent_y == 0 &&
            result.bitangent_z == 0)
        else $error("degenerate result carries nonzero vectors");

    a_busy_before_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(vertex_stall))
        else $error("result appeared without a solve in progress");

endmodule

bind triangle_tangent_solver tts_checker u_tts_checker (.*);

FILE: tb/triangle_tangent_solver_tb.sv
module triangle_tangent_solver_tb;
    import tts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        vertex_valid;
    logic        vertex_stall;
    tts_vertex_t vertex;
    logic        result_valid;
    logic        result_stall;
    tts_result_t result;

    tts_vertex_t pending_vertices[$];
    tts_result_t expected_results[$];

    logic [1:0]         pred_count;
    logic signed [31:0] pred_pos[6];
    logic signed [31:0] pred_tex[4];

    int  error_count = 0;
    int  idle_cycles;
    int  burst_left;
    int  gap_left;
    int  hold_left;
    bit  stimulus_done = 1'b0;
    bit  long_hold_req;

    triangle_tangent_solver #(.FRAC_BITS(FRAC)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic signed [31:0] quotient_sat(logic signed [127:0] num,
                                                        logic signed [127:0] det);
        logic signed [127:0] q;
        q = (num <<< FRAC) / det;
        if (q > 128'sh7FFF_FFFF)
            return SAT_MAX;
        if (q < -128'sh8000_0000)
            return SAT_MIN;
        return q[31:0];
    endfunction

    task automatic predict_vertex(tts_vertex_t v);
        logic signed [127:0] dp1[3];
        logic signed [127:0] dp2[3];
        logic signed [127:0] p3[3];
        logic signed [127:0] du1, dv1, du2, dv2, det, tn, bn;
        tts_result_t r;
        if (pred_count < 2)
        begin
            pred_pos[pred_count * 3]     = v.pos_x;
            pred_pos[pred_count * 3 + 1] = v.pos_y;
            pred_pos[pred_count * 3 + 2] = v.pos_z;
            pred_tex[pred_count * 2]     = v.tex_u;
            pred_tex[pred_count * 2 + 1] = v.tex_v;
            pred_count = pred_count + 1;
            return;
        end
        pred_count = 0;
        p3[0] = v.pos_x;
        p3[1] = v.pos_y;
        p3[2] = v.pos_z;
        for (int k = 0; k < 3; k++)
        begin
            dp1[k] = 128'(pred_pos[3 + k]) - 128'(pred_pos[k]);
            dp2[k] = p3[k] - 128'(pred_pos[k]);
        end
        du1 = 128'(pred_tex[2]) - 128'(pred_tex[0]);
        dv1 = 128'(pred_tex[3]) - 128'(pred_tex[1]);
        du2 = 128'(v.tex_u) - 128'(pred_tex[0]);
        dv2 = 128'(v.tex_v) - 128'(pred_tex[1]);
        det = du1 * dv2 - du2 * dv1;
        r = '0;
        if (det == 0)
            r.degenerate = 1'b1;
        else
        begin
            tn = dv2 * dp1[0] - dv1 * dp2[0];
            bn = du1 * dp2[0] - du2 * dp1[0];
            r.tangent_x   = quotient_sat(tn, det);
            r.bitangent_x = quotient_sat(bn, det);
            tn = dv2 * dp1[1] - dv1 * dp2[1];
            bn = du1 * dp2[1] - du2 * dp1[1];
            r.tangent_y   = quotient_sat(tn, det);
            r.bitangent_y = quotient_sat(bn, det);
            tn = dv2 * dp1[2] - dv1 * dp2[2];
            bn = du1 * dp2[2] - du2 * dp1[2];
            r.tangent_z   = quotient_sat(tn, det);
            r.bitangent_z = quotient_sat(bn, det);
        end
        expected_results.push_back(r);
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 8) << FRAC;
            3: return -($urandom_range(0, 8) << FRAC);
            4: return $urandom_range(0, 255) << $urandom_range(8, 24);
            default: return $urandom;
        endcase
    endfunction

    function automatic tts_vertex_t make_vertex(logic [31:0] x, logic [31:0] y,
                                                logic [31:0] z, logic [31:0] u,
                                                logic [31:0] v);
        tts_vertex_t t;
        t.pos_x = x;
        t.pos_y = y;
        t.pos_z = z;
        t.tex_u = u;
        t.tex_v = v;
        return t;
    endfunction

    function automatic tts_vertex_t random_vertex();
        return make_vertex(random_word(), random_word(), random_word(),
                           random_word(), random_word());
    endfunction

    // Stimulus: directed triangles first, then random ones.
    initial
    begin
        logic [31:0] one;
        logic [31:0] u0, v0;
        one = 32'h0001_0000;
        // Unit square mapping: tangent along x, bitangent along y.
        pending_vertices.push_back(make_vertex(0, 0, 0, 0, 0));
        pending_vertices.push_back(make_vertex(one, 0, 0, one, 0));
        pending_vertices.push_back(make_vertex(0, one, 0, 0, one));
        // Degenerate uv: all texture coordinates equal.
        pending_vertices.push_back(make_vertex(1, 2, 3, 5, 5));
        pending_vertices.push_back(make_vertex(4, 5, 6, 5, 5));
        pending_vertices.push_back(make_vertex(7, 8, 9, 5, 5));
        // Extremes that saturate in both directions.
        pending_vertices.push_back(make_vertex(32'h8000_0000, 32'h8000_0000,
                                               32'h7FFF_FFFF, 0, 0));
        pending_vertices.push_back(make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                               32'h8000_0000, 1, 0));
        pending_vertices.push_back(make_vertex(32'h8000_0000, 32'h7FFF_FFFF,
                                               32'h8000_0000, 0, 1));
        // Widest uv spread with all ones and all zeros patterns.
        pending_vertices.push_back(make_vertex(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF,
                                               32'h8000_0000, 32'h8000_0000));
        pending_vertices.push_back(make_vertex(0, 32'hFFFF_FFFF, 0,
                                               32'h7FFF_FFFF, 32'h8000_0000));
        pending_vertices.push_back(make_vertex(32'h5555_5555, 32'hAAAA_AAAA,
                                               32'h1234_5678, 32'h8000_0000,
                                               32'h7FFF_FFFF));
        // Truncation toward zero with negative quotients.
        pending_vertices.push_back(make_vertex(0, 0, 0, 0, 0));
        pending_vertices.push_back(make_vertex(-1, 1, 7, 3, 0));
        pending_vertices.push_back(make_vertex(1, -1, -7, 0, -3));
        for (int n = 0; n < 380; n++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                u0 = random_word();
                v0 = random_word();
                pending_vertices.push_back(make_vertex(random_word(), random_word(),
                                                       random_word(), u0, v0));
                pending_vertices.push_back(make_vertex(random_word(), random_word(),
                                                       random_word(), u0 + one,
                                                       v0 + one));
                pending_vertices.push_back(make_vertex(random_word(), random_word(),
                                                       random_word(), u0 + 2 * one,
                                                       v0 + 2 * one));
            end
            else
            begin
                pending_vertices.push_back(random_vertex());
                pending_vertices.push_back(random_vertex());
                pending_vertices.push_back(random_vertex());
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Sender: bursts and gaps; a stalled request is held unchanged.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_valid <= 1'b0;
            vertex <= '0;
            burst_left <= 0;
            gap_left <= 0;
            pred_count = 0;
        end
        else
        begin
            if (vertex_valid && !vertex_stall)
                predict_vertex(vertex);
            if (!vertex_valid || !vertex_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    vertex_valid <= 1'b0;
                end
                else if (pending_vertices.size() > 0)
                begin
                    vertex_valid <= 1'b1;
                    vertex <= pending_vertices.pop_front();
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                begin
                    vertex_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end
            end
        end
    end

    // Receiver: random stall pattern, one long hold-off early in the run.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left <= 0;
            long_hold_req <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (long_hold_req && expected_results.size() > 0)
        begin
            long_hold_req <= 1'b0;
            hold_left <= 1500;
            result_stall <= 1'b1;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: result_stall <= 1'b1;
                1: hold_left <= $urandom_range(0, 40);
                default: result_stall <= 1'b0;
            endcase
        end
    end

    // Result checker and watchdog.
    always @(posedge clk or negedge rst_n)
    begin
        tts_result_t exp_r;
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((vertex_valid && !vertex_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, result);
                    error_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (result.tangent_x !== exp_r.tangent_x ||
                        result.tangent_y !== exp_r.tangent_y ||
                        result.tangent_z !== exp_r.tangent_z ||
                        result.bitangent_x !== exp_r.bitangent_x ||
                        result.bitangent_y !== exp_r.bitangent_y ||
                        result.bitangent_z !== exp_r.bitangent_z ||
                        result.degenerate !== exp_r.degenerate)
                    begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, exp_r, result);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (!(stimulus_done && expected_results.size() == 0 && !vertex_valid)
               && idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (idle_cycles >= WATCHDOG_LIMIT || expected_results.size() != 0)
            $display("TB_ERROR");
        else if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/tts_pkg.sv
rtl/tts_datapath.sv
rtl/tts_ctrl.sv
rtl/triangle_tangent_solver.sv
rtl/tts_checker.sv
tb/triangle_tangent_solver_tb.sv
